@@ design/tbot_pkg.sv @@
// ---------------------------------------------------------------------------
// tbot_pkg
// Shared widths, command and status types and axis lookup functions for
// the triangle versus box overlap test.
// ---------------------------------------------------------------------------
`default_nettype none

package tbot_pkg;

    localparam int CW  = 24;
    localparam int LW  = CW + 2;
    localparam int HW  = CW + 1;
    localparam int EW  = CW + 1;
    localparam int NW  = 2 * CW + 3;
    localparam int NLW = CW + 1;
    localparam int MW  = CW + 3;
    localparam int PW  = 2 * MW;
    localparam int AW  = 3 * CW + 8;

    localparam logic [1:0] K_TEST  = 2'd3;
    localparam logic [1:0] GRP_RAD = 2'd3;
    localparam logic [1:0] GRP_LASTV = 2'd2;
    localparam logic [3:0] AX_NRM  = 4'd0;
    localparam logic [3:0] AX_LAST = 4'd9;
    localparam logic [2:0] T_NRM_LAST = 3'd5;
    localparam logic [2:0] T_CRS_LAST = 3'd1;
    localparam logic [2:0] T_GAP_LAST = 3'd1;

    typedef struct packed {
        logic       start;
        logic       load;
        logic       mac;
        logic       clr;
        logic       norm;
        logic       store_n;
        logic       end_proj;
        logic       end_rad;
        logic       cmp;
        logic       last;
        logic       out_load;
        logic [3:0] axis;
        logic [1:0] grp;
        logic [2:0] term;
    } t_cmd;

    typedef struct packed {
        logic fin;
    } t_stat;

    function automatic logic [1:0] f_nxt(input logic [1:0] i);
        logic [1:0] r;
        unique case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_axj(input logic [3:0] a);
        logic [1:0] r;
        unique case (a)
            4'd4, 4'd5, 4'd6: r = 2'd1;
            4'd7, 4'd8, 4'd9: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_axk(input logic [3:0] a);
        logic [1:0] r;
        unique case (a)
            4'd2, 4'd5, 4'd8: r = 2'd1;
            4'd3, 4'd6, 4'd9: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/triangle_box_overlap_test_core.sv @@
// ---------------------------------------------------------------------------
// triangle_box_overlap_test_core
// Separating axis overlap test of one stored triangle against boxes.
//
//   channel  dir  handshake          payload
//   in       in   i_valid / o_stall  i_kind, i_px..i_pz, i_qx..i_qz
//   out      out  o_valid / i_stall  o_overlap
//
// A load word goes straight into the vertex store. o_valid rises when a
// test word is done, and the next word can be taken as it rises: one shared
// 27x27 multiplier does six products for the normal, 24 for the normal axis
// and 8 for each of nine cross axes, with a compare step per axis, behind a
// three stage pipe. Reset clears the triangle to the origin. A result held
// by i_stall stalls only the next test word, at its last step.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_box_overlap_test_core import tbot_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic        [1:0]    i_kind,
    input  wire logic signed [CW-1:0] i_px,
    input  wire logic signed [CW-1:0] i_py,
    input  wire logic signed [CW-1:0] i_pz,
    input  wire logic signed [CW-1:0] i_qx,
    input  wire logic signed [CW-1:0] i_qy,
    input  wire logic signed [CW-1:0] i_qz,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_overlap
);

    t_cmd  cmd;
    t_stat stat;

    tbot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tbot_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_kind    (i_kind),
        .i_px      (i_px),
        .i_py      (i_py),
        .i_pz      (i_pz),
        .i_qx      (i_qx),
        .i_qy      (i_qy),
        .i_qz      (i_qz),
        .o_stat    (stat),
        .o_overlap (o_overlap)
    );

endmodule

`default_nettype wire

@@ design/tbot_dp.sv @@
// ---------------------------------------------------------------------------
// tbot_dp
// Datapath: vertex store, box locals, one shared multiplier and a
// three stage multiply, accumulate and compare pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module tbot_dp import tbot_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic        [1:0]    i_kind,
    input  wire logic signed [CW-1:0] i_px,
    input  wire logic signed [CW-1:0] i_py,
    input  wire logic signed [CW-1:0] i_pz,
    input  wire logic signed [CW-1:0] i_qx,
    input  wire logic signed [CW-1:0] i_qy,
    input  wire logic signed [CW-1:0] i_qz,
    output t_stat                     o_stat,
    output logic                      o_overlap
);

    logic signed [CW-1:0] r_vert [3][3];
    logic signed [LW-1:0] r_loc  [3][3];
    logic signed [HW-1:0] r_h2   [3];
    logic signed [NW-1:0] r_nrm  [3];
    logic signed [NW-1:0] nabs   [3];
    logic signed [EW-1:0] e      [3][3];
    logic signed [CW-1:0] pin    [3];
    logic signed [CW-1:0] qin    [3];

    logic signed [MW-1:0] opa, opb;
    logic                 neg0, sh0;
    logic [1:0]           u, v, c, j, k;
    logic signed [NW-1:0] src;
    logic signed [EW-1:0] ev, eabs;

    logic signed [PW-1:0] r_prod;
    logic                 r_neg1, r_sh1;
    t_cmd                 r_cmd1, r_cmd2;
    logic signed [AW-1:0] r_acc, r_lo, r_hi, r_rad;
    logic signed [AW-1:0] t_ext, t_sh, t_term;
    logic                 r_sep, r_res, sep_now, box_sep;

    assign pin[0] = i_px;
    assign pin[1] = i_py;
    assign pin[2] = i_pz;
    assign qin[0] = i_qx;
    assign qin[1] = i_qy;
    assign qin[2] = i_qz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[0][i] = {r_vert[1][i][CW-1], r_vert[1][i]} - {r_vert[0][i][CW-1], r_vert[0][i]};
            e[1][i] = {r_vert[2][i][CW-1], r_vert[2][i]} - {r_vert[1][i][CW-1], r_vert[1][i]};
            e[2][i] = {r_vert[0][i][CW-1], r_vert[0][i]} - {r_vert[2][i][CW-1], r_vert[2][i]};
            nabs[i] = r_nrm[i][NW-1] ? -r_nrm[i] : r_nrm[i];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW:0] c2;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_vert[a][i] <= '0;
                end
            end
        end else if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_vert[i_kind][i] <= pin[i];
            end
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 3; i++) begin
                c2 = {pin[i][CW-1], pin[i]} + {qin[i][CW-1], qin[i]};
                r_h2[i] <= {qin[i][CW-1], qin[i]} - {pin[i][CW-1], pin[i]};
                for (int a = 0; a < 3; a++) begin
                    r_loc[a][i] <= {r_vert[a][i][CW-1], r_vert[a][i], 1'b0} - {c2[CW], c2};
                end
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        opa  = '0;
        opb  = '0;
        neg0 = 1'b0;
        sh0  = 1'b0;
        u    = f_nxt(i_cmd.grp);
        v    = f_nxt(u);
        c    = i_cmd.term[2:1];
        j    = f_axj(i_cmd.axis);
        k    = f_axk(i_cmd.axis);
        src  = r_nrm[0];
        ev   = e[0][0];
        eabs = ev;
        if (i_cmd.norm) begin
            if (!i_cmd.term[0]) begin
                opa = MW'(e[0][u]);
                opb = MW'(e[1][v]);
            end else begin
                opa  = MW'(e[0][v]);
                opb  = MW'(e[1][u]);
                neg0 = 1'b1;
            end
        end else if (i_cmd.axis == AX_NRM) begin
            sh0 = i_cmd.term[0];
            if (i_cmd.grp == GRP_RAD) begin
                opa = MW'(r_h2[c]);
                src = nabs[c];
            end else begin
                opa = MW'(r_loc[i_cmd.grp][c]);
                src = r_nrm[c];
            end
            if (i_cmd.term[0]) begin
                opb = MW'($signed(src[NW-1:NLW]));
            end else begin
                opb = MW'({1'b0, src[NLW-1:0]});
            end
        end else begin
            u    = f_nxt(j);
            v    = f_nxt(u);
            c    = i_cmd.term[0] ? v : u;
            ev   = i_cmd.term[0] ? e[k][u] : e[k][v];
            eabs = ev[EW-1] ? -ev : ev;
            if (i_cmd.grp == GRP_RAD) begin
                opa = MW'(r_h2[c]);
                opb = MW'(eabs);
            end else begin
                opa  = MW'(r_loc[i_cmd.grp][c]);
                opb  = MW'(ev);
                neg0 = !i_cmd.term[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
        r_neg1 <= neg0;
        r_sh1  <= sh0;
        if (!i_rst_n) begin
            r_cmd1 <= '0;
            r_cmd2 <= '0;
        end else begin
            r_cmd1 <= i_cmd;
            r_cmd2 <= r_cmd1;
        end
    end

    always_comb begin
        t_ext  = AW'(r_prod);
        t_sh   = r_sh1 ? (t_ext <<< NLW) : t_ext;
        t_term = r_neg1 ? -t_sh : t_sh;
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd1.mac) begin
            r_acc <= (r_cmd1.clr ? '0 : r_acc) + t_term;
        end
    end

    // box axes straight from the locals
    always_comb begin
        logic signed [LW-1:0] tmin, tmax, mh, ph, m, r;
        box_sep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            tmin = r_loc[0][i];
            tmax = r_loc[0][i];
            for (int a = 1; a < 3; a++) begin
                if (r_loc[a][i] < tmin) tmin = r_loc[a][i];
                if (r_loc[a][i] > tmax) tmax = r_loc[a][i];
            end
            ph = LW'(r_h2[i]);
            mh = -ph;
            m  = (tmin > mh) ? tmin : mh;
            r  = (tmax < ph) ? tmax : ph;
            if (m > r) box_sep = 1'b1;
        end
    end

    assign sep_now    = (r_rad < r_lo) || (r_hi < -r_rad);
    assign o_stat.fin = r_cmd2.cmp && r_cmd2.last;

    always_ff @(posedge i_clk) begin
        if (r_cmd2.store_n) begin
            r_nrm[r_cmd2.grp] <= r_acc[NW-1:0];
        end
        if (r_cmd2.end_proj) begin
            if (r_cmd2.grp == 2'd0) begin
                r_lo <= r_acc;
                r_hi <= r_acc;
            end else begin
                if (r_acc < r_lo) r_lo <= r_acc;
                if (r_acc > r_hi) r_hi <= r_acc;
            end
        end
        if (r_cmd2.end_rad) begin
            r_rad <= r_acc;
        end
        if (i_cmd.start) begin
            r_sep <= 1'b0;
        end else if (r_cmd2.cmp && sep_now) begin
            r_sep <= 1'b1;
        end
        if (o_stat.fin) begin
            r_res <= !(r_sep || sep_now || box_sep);
        end
        if (i_cmd.out_load) begin
            o_overlap <= r_res;
        end
    end

endmodule

`default_nettype wire

@@ design/tbot_ctrl.sv @@
// ---------------------------------------------------------------------------
// tbot_ctrl
// Sequencer: walks the normal build, the ten axis projections and
// the result handoff, and owns the handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module tbot_ctrl import tbot_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_kind,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NORM  = 3'd1;
    localparam logic [2:0] S_GAP   = 3'd2;
    localparam logic [2:0] S_PROJ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_axis, n_axis;
    logic [1:0] r_grp, n_grp;
    logic [2:0] r_term, n_term;
    logic       r_out_valid, n_out_valid;
    logic       in_acc, out_free, tlast;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign tlast    = (r_state == S_NORM) ? (r_term == T_CRS_LAST) :
                      (r_axis == AX_NRM) ? (r_term == T_NRM_LAST) : (r_term == T_CRS_LAST);

    always_comb begin
        o_cmd          = '0;
        o_cmd.axis     = r_axis;
        o_cmd.grp      = r_grp;
        o_cmd.term     = r_term;
        n_state        = r_state;
        n_axis         = r_axis;
        n_grp          = r_grp;
        n_term         = r_term;
        n_out_valid    = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.start = in_acc && (i_kind == K_TEST);
                o_cmd.load  = in_acc && (i_kind != K_TEST);
                n_axis = '0;
                n_grp  = '0;
                n_term = '0;
                if (o_cmd.start) n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.mac     = 1'b1;
                o_cmd.norm    = 1'b1;
                o_cmd.clr     = (r_term == 3'd0);
                o_cmd.store_n = tlast;
                if (tlast) begin
                    n_term = '0;
                    if (r_grp == GRP_LASTV) begin
                        n_grp   = '0;
                        n_state = S_GAP;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            S_GAP: begin
                if (r_term == T_GAP_LAST) begin
                    n_term  = '0;
                    n_state = S_PROJ;
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            S_PROJ: begin
                o_cmd.mac      = 1'b1;
                o_cmd.clr      = (r_term == 3'd0);
                o_cmd.end_proj = tlast && (r_grp != GRP_RAD);
                o_cmd.end_rad  = tlast && (r_grp == GRP_RAD);
                if (tlast) begin
                    n_term = '0;
                    n_grp  = r_grp + 2'd1;
                    if (r_grp == GRP_RAD) n_state = S_CMP;
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            S_CMP: begin
                o_cmd.cmp  = 1'b1;
                o_cmd.last = (r_axis == AX_LAST);
                n_grp      = '0;
                n_term     = '0;
                if (r_axis == AX_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_axis  = r_axis + 4'd1;
                    n_state = S_PROJ;
                end
            end
            S_DRAIN: begin
                if (i_stat.fin) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_grp       <= '0;
            r_term      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_grp       <= n_grp;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

    a_fin_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.fin |-> (r_state == S_DRAIN))
        else $error("finish status outside drain");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result register overwritten while held");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == K_TEST) |=> (o_stall && r_state == S_NORM))
        else $error("test word did not start the sequence");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROJ && r_axis != AX_NRM) |-> (r_term <= T_CRS_LAST))
        else $error("cross axis term counter out of range");

endmodule

`default_nettype wire
